@@ hw/rtl/pire_pkg.sv @@
// pire_pkg: shared types, constants and helpers for the palette index row expander
// used by palette_index_row_expander; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pire_pkg;

  localparam int PIRE_PALETTE_DEPTH = 256;
  localparam int PIRE_MAX_ROW_WIDTH = 16384;
  localparam int PIRE_CFG_W         = 15;
  localparam int PIRE_CFG_IDX_W     = 2;
  localparam int PIRE_ENTRY_W       = 24;

  // request operation codes
  localparam logic OP_PAL_WRITE = 1'b0;
  localparam logic OP_PIXEL     = 1'b1;

  // configuration register indexes
  localparam logic [PIRE_CFG_IDX_W-1:0] CFG_IDX_MODE  = 2'd0;
  localparam logic [PIRE_CFG_IDX_W-1:0] CFG_IDX_GRAY  = 2'd1;
  localparam logic [PIRE_CFG_IDX_W-1:0] CFG_IDX_WIDTH = 2'd2;

  // index width modes
  localparam logic [1:0] MODE_1BIT = 2'd0;
  localparam logic [1:0] MODE_2BIT = 2'd1;
  localparam logic [1:0] MODE_4BIT = 2'd2;
  localparam logic [1:0] MODE_8BIT = 2'd3;

  typedef struct packed {
    logic       operation;
    logic [7:0] entry_index;
    logic [7:0] entry_blue;
    logic [7:0] entry_green;
    logic [7:0] entry_red;
    logic [7:0] pixel_byte;
  } pire_in_t;

  typedef struct packed {
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
    logic       last_of_byte;
    logic       end_of_row;
  } pire_out_t;

  // index at position pos of a packed byte, most significant index first
  function automatic logic [7:0] pick_index(input logic [7:0] pix, input logic [1:0] mode,
                                            input logic [2:0] pos);
    logic [7:0] idx;
    logic [2:0] sh;
    sh  = '0;
    idx = '0;
    case (mode)
      MODE_1BIT: begin
        sh  = 3'd7 - pos;
        idx = (pix >> sh) & 8'h01;
      end
      MODE_2BIT: begin
        sh  = {2'd3 - pos[1:0], 1'b0};
        idx = (pix >> sh) & 8'h03;
      end
      MODE_4BIT: begin
        idx = pos[0] ? (pix & 8'h0F) : ((pix >> 4) & 8'h0F);
      end
      MODE_8BIT: begin
        idx = pix;
      end
      default: begin
        idx = pix;
      end
    endcase
    return idx;
  endfunction

  // position of the last index in a byte
  function automatic logic [2:0] last_pos(input logic [1:0] mode);
    return 3'd7 >> mode;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/palette_index_row_expander.sv @@
// palette_index_row_expander: expands packed palette indices into pixels through a palette ram
// depends on pire_pkg and pire_ram
//
//   channel | direction | handshake           | payload
//   in_     | input     | in_valid / in_stall  | pire_in_t (palette write or pixel byte)
//   out_    | output    | out_valid / out_stall| pire_out_t (one pixel)
//   cfg_    | input     | cfg_we               | cfg_index, cfg_wdata
//
// at most one pixel leaves per cycle while out_stall is low; a pixel byte holds the issue stage
// until its last index issues (earlier at the row end), a palette write until it is written
// the palette ram read port sets the pace: one index lookup per cycle while the pipeline is not frozen
// a byte passes the issue stage, then the palette ram read register, then the output register
// reset is synchronous; the palette holds no reset and is never cleared
// a stalled output fills a one entry skid register, then the pipeline freezes
`timescale 1ns / 1ps
`default_nettype none

module palette_index_row_expander
  import pire_pkg::*;
#(
  parameter int PALETTE_DEPTH = PIRE_PALETTE_DEPTH,
  parameter int MAX_ROW_WIDTH = PIRE_MAX_ROW_WIDTH
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire pire_in_t                  in_data,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output pire_out_t                      out_data,
  input  wire logic                      cfg_we,
  input  wire logic [PIRE_CFG_IDX_W-1:0] cfg_index,
  input  wire logic [PIRE_CFG_W-1:0]     cfg_wdata
);

  localparam int AW = $clog2(PALETTE_DEPTH);
  localparam int CW = $clog2(MAX_ROW_WIDTH);
  localparam int EW = (CW + 1 > PIRE_CFG_W) ? CW + 1 : PIRE_CFG_W;

  // configuration
  logic [1:0]            cfg_mode_r;
  logic                  cfg_gray_r;
  logic [PIRE_CFG_W-1:0] cfg_row_width_r;

  // issue stage
  logic          s0_valid_r;
  pire_in_t      s0_data_r;
  logic [2:0]    s0_pos_r;
  logic [2:0]    s0_pos_nxt;
  logic [CW-1:0] col_r;
  logic [CW-1:0] col_nxt;

  // lookup stage
  logic s1_valid_r;
  logic s1_oob_r;
  logic s1_last_r;
  logic s1_eor_r;

  // output side
  logic      skid_valid_r;
  pire_out_t skid_data_r;
  logic      out_valid_r;
  pire_out_t out_data_r;

  logic [EW-1:0]           row_ext;
  logic [EW-1:0]           eff;
  logic [CW-1:0]           col_use;
  logic [EW-1:0]           col_inc;
  logic                    row_end;
  logic                    en;
  logic                    issue;
  logic                    pix_issue;
  logic                    s0_done;
  logic                    idx_last;
  logic [7:0]              idx;
  logic                    idx_oob;
  logic                    wr_oob;
  logic                    in_acc;
  logic                    out_free;
  logic                    ram_we;
  logic [PIRE_ENTRY_W-1:0] ram_wdata;
  logic [PIRE_ENTRY_W-1:0] ram_rdata;
  pire_out_t               s1_pixel;

  always_comb begin
    row_ext = EW'(cfg_row_width_r);
    if (row_ext == '0) begin
      eff = EW'(1);
    end else if (row_ext > EW'(MAX_ROW_WIDTH)) begin
      eff = EW'(MAX_ROW_WIDTH);
    end else begin
      eff = row_ext;
    end
  end

  // restart the row when the width was lowered to or below the current column
  assign col_use = (EW'(col_r) >= eff) ? '0 : col_r;
  assign col_inc = EW'(col_use) + EW'(1);
  assign row_end = (col_inc == eff);

  assign en        = !skid_valid_r;
  assign issue     = en && s0_valid_r;
  assign pix_issue = issue && (s0_data_r.operation == OP_PIXEL);
  assign idx       = pick_index(s0_data_r.pixel_byte, cfg_mode_r, s0_pos_r);
  assign idx_last  = (s0_pos_r == last_pos(cfg_mode_r)) || row_end;
  assign s0_done   = (s0_data_r.operation == OP_PAL_WRITE) || idx_last;
  assign idx_oob   = 9'(idx) >= 9'(PALETTE_DEPTH);
  assign wr_oob    = 9'(s0_data_r.entry_index) >= 9'(PALETTE_DEPTH);

  assign in_stall = s0_valid_r && !(issue && s0_done);
  assign in_acc   = in_valid && !in_stall;

  assign s0_pos_nxt = !issue ? s0_pos_r : (s0_done ? '0 : s0_pos_r + 3'd1);
  assign col_nxt    = pix_issue ? (row_end ? '0 : CW'(col_inc)) : col_r;

  // one access per cycle: a write is always visible to the next lookup
  assign ram_we    = issue && (s0_data_r.operation == OP_PAL_WRITE) && !wr_oob;
  assign ram_wdata = {s0_data_r.entry_red, s0_data_r.entry_green, s0_data_r.entry_blue};

  pire_ram #(
    .WIDTH(PIRE_ENTRY_W),
    .DEPTH(PALETTE_DEPTH)
  ) u_palette (
    .clk  (clk),
    .we   (ram_we),
    .waddr(s0_data_r.entry_index[AW-1:0]),
    .wdata(ram_wdata),
    .re   (pix_issue),
    .raddr(idx[AW-1:0]),
    .rdata(ram_rdata)
  );

  always_comb begin
    s1_pixel.out_blue     = s1_oob_r ? 8'd0 : ram_rdata[7:0];
    s1_pixel.out_green    = (s1_oob_r || cfg_gray_r) ? 8'd0 : ram_rdata[15:8];
    s1_pixel.out_red      = (s1_oob_r || cfg_gray_r) ? 8'd0 : ram_rdata[23:16];
    s1_pixel.last_of_byte = s1_last_r;
    s1_pixel.end_of_row   = s1_eor_r;
  end

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_mode_r      <= MODE_8BIT;
      cfg_gray_r      <= 1'b0;
      cfg_row_width_r <= PIRE_CFG_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IDX_MODE:  cfg_mode_r      <= cfg_wdata[1:0];
        CFG_IDX_GRAY:  cfg_gray_r      <= cfg_wdata[0];
        CFG_IDX_WIDTH: cfg_row_width_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
      s0_pos_r   <= '0;
      col_r      <= '0;
    end else begin
      col_r    <= col_nxt;
      s0_pos_r <= s0_pos_nxt;
      if (in_acc) begin
        s0_valid_r <= 1'b1;
      end else if (issue && s0_done) begin
        s0_valid_r <= 1'b0;
      end
    end
    if (in_acc) begin
      s0_data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= pix_issue;
    end
    if (pix_issue) begin
      s1_oob_r  <= idx_oob;
      s1_last_r <= idx_last;
      s1_eor_r  <= row_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_free) begin
        out_valid_r  <= 1'b1;
        out_data_r   <= skid_data_r;
        skid_valid_r <= 1'b0;
      end
    end else if (s1_valid_r) begin
      if (out_free) begin
        out_valid_r <= 1'b1;
        out_data_r  <= s1_pixel;
      end else begin
        skid_valid_r <= 1'b1;
        skid_data_r  <= s1_pixel;
      end
    end else if (out_free) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register full while output register empty");

  a_row_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (pix_issue && row_end) |=> (col_r == '0))
    else $error("column counter did not restart after row end");

  a_row_end_ends_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.end_of_row) |-> out_data_r.last_of_byte)
    else $error("row end pixel not marked as last of byte");

  a_frozen_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && s1_valid_r) |=> (s1_valid_r && $stable(ram_rdata)))
    else $error("lookup stage lost data while frozen");

endmodule

`default_nettype wire

@@ hw/rtl/pire_ram.sv @@
// pire_ram: generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module pire_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
